// ===== sv/dpnf_pkg.sv =====
// ----------------------------------------------------------------------------
// dpnf_pkg
// Shared constants and helpers of the dark pixel neighbour fill core.
// ----------------------------------------------------------------------------
`default_nettype none

package dpnf_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned IMG_W_W  = 11;
  localparam int unsigned IMG_H_W  = 16;
  localparam int unsigned ROW_W    = IMG_H_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PIX_W-1:0]   THRESHOLD_RST = 8'd20;
  localparam logic [IMG_W_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST    = 16'd480;

  localparam logic [IMG_W_W-1:0] WIDTH_MIN  = 11'd3;
  localparam logic [IMG_H_W-1:0] HEIGHT_MIN = 16'd3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam int unsigned OUT_DEPTH = 4;

  // truncated mean of three pixels, reciprocal multiply by 683 / 2048
  function automatic logic [PIX_W-1:0] mean3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(a) + 10'(b) + 10'(c);
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dark_pixel_neighbour_fill_core.sv =====
// ----------------------------------------------------------------------------
// dark_pixel_neighbour_fill_core
// Raster stream dark pixel repair with one line memory and a 3x3 window.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per pixel in raster order: tdata is the pixel,
//   tuser set marks a flush item that drains the tail of the frame once all
//   pixels have arrived (a flush before that is dropped without effect).
//   m_axis returns the repaired pixel in tdata, tlast on the final pixel.
//   cfg writes threshold, image width or image height; the user does so only
//   while the core is idle (not enforced); width or height restarts the frame.
// Timing:
//   One item per clock while s_axis_tready is high. In raster terms output
//   lags input by one row plus one pixel. The pace is set by the single line
//   memory, one read and one write per item, holding the two stored rows side
//   by side in one word.
// Reset and stall:
//   Reset clears counters, window and the output queue; the line memory is
//   not cleared. When m_axis stalls the four entry output queue fills and
//   s_axis_tready drops, so no result is lost.
`default_nettype none

module dark_pixel_neighbour_fill_core #(
  parameter int unsigned MAX_WIDTH = dpnf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [dpnf_pkg::PIX_W-1:0]           s_axis_tdata,  // pixel_in
  input  wire logic                                 s_axis_tuser,  // mode
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [dpnf_pkg::PIX_W-1:0]                m_axis_tdata,  // pixel_out
  output logic                                      m_axis_tlast,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [dpnf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [dpnf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned PW     = dpnf_pkg::PIX_W;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WCMP_W = (CNT_W > dpnf_pkg::IMG_W_W) ? CNT_W : dpnf_pkg::IMG_W_W;
  localparam int unsigned ROW_W  = dpnf_pkg::ROW_W;
  localparam int unsigned DEPTH  = dpnf_pkg::OUT_DEPTH;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned QCNT_W = $clog2(DEPTH + 1);

  // configuration
  logic [PW-1:0]                     thr_q;
  logic [dpnf_pkg::IMG_W_W-1:0]      width_q;
  logic [dpnf_pkg::IMG_H_W-1:0]      height_q;
  logic                              cfg_fire;
  logic                              restart;

  // frame position
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] w_eff;
  logic [WCMP_W-1:0] wreg_ext;
  logic [dpnf_pkg::IMG_H_W-1:0] h_eff;
  logic [ROW_W-1:0] h_ext;
  logic             draining;
  logic             s_fire;
  logic             proc;
  logic             col_wrap;
  logic             is_last;

  // stage 1: memory read in flight
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PW-1:0]    s1_v_q;
  logic             s1_edge_q, s1_center_q, s1_border_q, s1_last_q;
  logic [2*PW-1:0]  rd_data_q;
  logic [2*PW-1:0]  fwd_data_q;
  logic             fwd_hit_q;
  logic [2*PW-1:0]  rd_word;
  logic [PW-1:0]    rd_up, rd_mid;
  logic [2*PW-1:0]  wr_word;
  logic [2*PW-1:0]  line_mem [MAX_WIDTH];
  logic [PW-1:0]    prev_mid_q;

  // stage 2: window holds the item
  logic [PW-1:0]    win_q [9];
  logic             s2_valid_q;
  logic             s2_edge_q, s2_border_q, s2_last_q;
  logic [PW-1:0]    s2_edge_val_q;
  logic [PW-1:0]    res_val;

  // output queue
  logic [PW:0]         q_mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   q_cnt_q;
  logic [QCNT_W-1:0]   q_used;
  logic                push, pop;

  // --------------------------------------------------------------------------
  // configuration port
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_fire && (cfg_index_i == dpnf_pkg::REG_WIDTH ||
                                    cfg_index_i == dpnf_pkg::REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= dpnf_pkg::THRESHOLD_RST;
      width_q  <= dpnf_pkg::WIDTH_RST;
      height_q <= dpnf_pkg::HEIGHT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        dpnf_pkg::REG_THRESHOLD: thr_q    <= cfg_data_i[PW-1:0];
        dpnf_pkg::REG_WIDTH:     width_q  <= cfg_data_i[dpnf_pkg::IMG_W_W-1:0];
        dpnf_pkg::REG_HEIGHT:    height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    wreg_ext = WCMP_W'(width_q);
    if (width_q < dpnf_pkg::WIDTH_MIN) begin
      w_eff = CNT_W'(dpnf_pkg::WIDTH_MIN);
    end else if (wreg_ext > WCMP_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(width_q);
    end
    h_eff = (height_q < dpnf_pkg::HEIGHT_MIN) ? dpnf_pkg::HEIGHT_MIN : height_q;
  end

  assign h_ext    = ROW_W'(h_eff);
  assign draining = row_q >= h_ext;

  // --------------------------------------------------------------------------
  // input side
  assign q_used        = q_cnt_q + QCNT_W'(s1_valid_q) + QCNT_W'(s2_valid_q);
  assign s_axis_tready = q_used < QCNT_W'(DEPTH);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign proc          = s_fire && !(s_axis_tuser && !draining);
  assign col_wrap      = (CNT_W'({1'b0, col_q}) + CNT_W'(1)) >= w_eff;
  assign is_last       = (col_q == '0) && (row_q == h_ext + ROW_W'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (proc) begin
      if (is_last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= proc;
      fwd_hit_q  <= proc && s1_valid_q && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      s1_col_q    <= col_q;
      s1_v_q      <= draining ? '0 : s_axis_tdata;
      s1_edge_q   <= (col_q == '0) && (row_q >= ROW_W'(2));
      s1_center_q <= (col_q != '0) && (row_q != '0);
      s1_border_q <= (row_q == ROW_W'(1)) || draining || (col_q == COL_W'(1));
      s1_last_q   <= is_last;
      fwd_data_q  <= wr_word;
    end
  end

  // --------------------------------------------------------------------------
  // line memory: word holds {upper row, middle row} of one column
  assign rd_word = fwd_hit_q ? fwd_data_q : rd_data_q;
  assign rd_up   = rd_word[2*PW-1:PW];
  assign rd_mid  = rd_word[PW-1:0];
  assign wr_word = {rd_mid, s1_v_q};

  always_ff @(posedge clk_i) begin
    if (proc) begin
      rd_data_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= wr_word;
    end
  end

  // --------------------------------------------------------------------------
  // window shift and stage 2 tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && (s1_edge_q || s1_center_q);
      if (s1_valid_q) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= rd_up;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= rd_mid;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      prev_mid_q    <= rd_mid;
      s2_edge_q     <= s1_edge_q;
      s2_border_q   <= s1_border_q;
      s2_last_q     <= s1_last_q;
      s2_edge_val_q <= prev_mid_q;
    end
  end

  // fill decision
  always_comb begin
    if (s2_edge_q) begin
      res_val = s2_edge_val_q;
    end else if (s2_border_q || win_q[4] >= thr_q) begin
      res_val = win_q[4];
    end else if (win_q[1] >= thr_q) begin
      res_val = dpnf_pkg::mean3(win_q[0], win_q[1], win_q[2]);
    end else if (win_q[7] >= thr_q) begin
      res_val = dpnf_pkg::mean3(win_q[6], win_q[7], win_q[8]);
    end else if (win_q[3] >= thr_q) begin
      res_val = dpnf_pkg::mean3(win_q[0], win_q[3], win_q[6]);
    end else if (win_q[5] >= thr_q) begin
      res_val = dpnf_pkg::mean3(win_q[2], win_q[5], win_q[8]);
    end else begin
      res_val = win_q[4];
    end
  end

  // --------------------------------------------------------------------------
  // output queue
  assign push = s2_valid_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      q_cnt_q <= q_cnt_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= {s2_last_q, res_val};
    end
  end

  assign m_axis_tvalid = q_cnt_q != '0;
  assign m_axis_tdata  = q_mem[rd_ptr_q][PW-1:0];
  assign m_axis_tlast  = q_mem[rd_ptr_q][PW];

  // --------------------------------------------------------------------------
  // assertions
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> q_cnt_q < QCNT_W'(DEPTH))
    else $error("output queue overflow");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'({1'b0, col_q}) < w_eff)
    else $error("column counter beyond row width");

  a_last_is_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_last_q |-> s2_edge_q)
    else $error("frame end tagged on a non edge pixel");

  a_proc_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> s1_valid_q)
    else $error("accepted item lost before memory stage");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && is_last |=> col_q == '0 && row_q == '0)
    else $error("counters not cleared after frame end");

endmodule

`default_nettype wire

// ===== verif/dark_pixel_neighbour_fill_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dark_pixel_neighbour_fill_core_tb
// Streams small raster frames through the core. A predictor tracks the line
// stores, the 3x3 window and the frame counters and queues each repaired
// pixel. Results are compared field by field, in order, against that queue.
// Random idling on both ports, one long output stall, and a range of register
// settings from the clamp limits to the widest line.
// ----------------------------------------------------------------------------

module dark_pixel_neighbour_fill_core_tb;

  import dpnf_pkg::*;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int DIR_ROWS = 28;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } out_pix_t;

  typedef struct packed {
    logic             flush;
    logic [PIX_W-1:0] pix;
    logic             typed;
    logic [PIX_W-1:0] exp_pix;
    logic             exp_last;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dark_pixel_neighbour_fill_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [PIX_W-1:0]   row_above [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   row_mid   [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   nbhd      [9];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [PIX_W-1:0]   thr_reg;
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;

  out_pix_t    expected_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned fed_items = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  bit          squeeze_req = 1'b0;

  // second frame: corners bright, edges dark, all four center neighbours dark
  dir_row_t dir_table [DIR_ROWS] = '{
    '{MODE_FLUSH, 8'hAA, 1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd255, 1'b0, 8'd0,  1'b0},
    '{MODE_PIXEL, 8'd0,   1'b0, 8'd0,  1'b0},
    '{MODE_PIXEL, 8'd128, 1'b0, 8'd0,  1'b0},
    '{MODE_PIXEL, 8'd25,  1'b0, 8'd0,  1'b0},
    '{MODE_PIXEL, 8'd5,   1'b1, 8'd255, 1'b0},
    '{MODE_FLUSH, 8'h55,  1'b0, 8'd0,  1'b0},
    '{MODE_PIXEL, 8'd30,  1'b1, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd0,   1'b1, 8'd128, 1'b0},
    '{MODE_PIXEL, 8'd19,  1'b1, 8'd25,  1'b0},
    '{MODE_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{MODE_FLUSH, 8'h3C,  1'b1, 8'd30,  1'b0},
    '{MODE_PIXEL, 8'h77,  1'b1, 8'd0,   1'b0},
    '{MODE_FLUSH, 8'h00,  1'b1, 8'd19,  1'b0},
    '{MODE_FLUSH, 8'hFF,  1'b1, 8'd255, 1'b1},
    '{MODE_PIXEL, 8'd200, 1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd200, 1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd3,   1'b1, 8'd200, 1'b0},
    '{MODE_PIXEL, 8'd0,   1'b1, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd200, 1'b1, 8'd200, 1'b0},
    '{MODE_PIXEL, 8'd0,   1'b1, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd200, 1'b1, 8'd3,   1'b0},
    '{MODE_FLUSH, 8'h81,  1'b1, 8'd0,   1'b0},
    '{MODE_FLUSH, 8'h42,  1'b1, 8'd200, 1'b0},
    '{MODE_FLUSH, 8'h18,  1'b1, 8'd0,   1'b0},
    '{MODE_FLUSH, 8'hE7,  1'b1, 8'd200, 1'b1}
  };

  function automatic int unsigned eff_w();
    if (width_reg < WIDTH_MIN) return int'(WIDTH_MIN);
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg < HEIGHT_MIN) ? int'(HEIGHT_MIN) : int'(height_reg);
  endfunction

  function automatic logic [PIX_W-1:0] avg3(input int unsigned a, input int unsigned b,
                                            input int unsigned c);
    return PIX_W'((a + b + c) / 3);
  endfunction

  function automatic logic [PIX_W-1:0] fill_dark_center();
    if (nbhd[4] >= thr_reg) return nbhd[4];
    if (nbhd[1] >= thr_reg) return avg3(nbhd[0], nbhd[1], nbhd[2]);
    if (nbhd[7] >= thr_reg) return avg3(nbhd[6], nbhd[7], nbhd[8]);
    if (nbhd[3] >= thr_reg) return avg3(nbhd[0], nbhd[3], nbhd[6]);
    if (nbhd[5] >= thr_reg) return avg3(nbhd[2], nbhd[5], nbhd[8]);
    return nbhd[4];
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD: thr_reg = data[PIX_W-1:0];
      REG_WIDTH: begin
        width_reg = data[IMG_W_W-1:0];
        restart_frame();
      end
      REG_HEIGHT: begin
        height_reg = data[IMG_H_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the item releases a repaired pixel
  function automatic bit predict_fill(input logic flush, input logic [PIX_W-1:0] pix,
                                      output out_pix_t res);
    int unsigned w, h, c, r, pr, pc;
    logic [PIX_W-1:0] v;
    bit have;
    w = eff_w();
    h = eff_h();
    have = 1'b0;
    pr = 0;
    pc = 0;
    res = '0;
    if (col_pos >= w) col_pos = 0;
    c = col_pos;
    r = row_pos;
    if (flush == MODE_FLUSH && r < h) return 1'b0;
    v = (r >= h) ? '0 : pix;
    if (c == 0 && r >= 2) begin
      res.pix = row_above[w-1];
      pr = r - 2;
      pc = w - 1;
      have = 1'b1;
    end
    nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2];
    nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5];
    nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8];
    nbhd[2] = row_above[c];
    nbhd[5] = row_mid[c];
    nbhd[8] = v;
    row_above[c] = row_mid[c];
    row_mid[c] = v;
    if (c >= 1 && r >= 1) begin
      pr = r - 1;
      pc = c - 1;
      if (pr == 0 || pr >= h - 1 || pc == 0 || pc >= w - 1) res.pix = nbhd[4];
      else res.pix = fill_dark_center();
      have = 1'b1;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (!have) return 1'b0;
    res.last = (pr == h - 1 && pc == w - 1);
    if (res.last) restart_frame();
    return 1'b1;
  endfunction

  function automatic void check_result(input logic [PIX_W-1:0] pix, input logic last);
    out_pix_t exp_res;
    if (expected_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected item: pixel %0d last %0b", pix, last);
      return;
    end
    exp_res = expected_pixels.pop_front();
    if (pix !== exp_res.pix || last !== exp_res.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                 exp_res.pix, exp_res.last, pix, last);
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (thr_reg == 0) return PIX_W'($urandom);
        return PIX_W'($urandom_range(0, int'(thr_reg) - 1));
      end
      4, 5, 6, 7: return PIX_W'($urandom_range(int'(thr_reg), 255));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic flush, input logic [PIX_W-1:0] pix,
                           input logic typed = 1'b0, input out_pix_t typed_res = '0);
    out_pix_t res;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= flush;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_fill(flush, pix, res)) expected_pixels.push_back(typed ? typed_res : res);
  endtask

  task automatic send_frame(input bit cut);
    int unsigned w, h, n;
    w = eff_w();
    h = eff_h();
    n = cut ? $urandom_range(1, w * h - 1) : w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) send_item(MODE_FLUSH, PIX_W'($urandom));
      send_item(MODE_PIXEL, pick_pixel());
    end
    fed_items += n;
    if (!cut) begin
      for (int unsigned i = 0; i <= w; i++)
        send_item(($urandom_range(0, 3) == 0) ? MODE_PIXEL : MODE_FLUSH, PIX_W'($urandom));
      fed_items += w + 1;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_d, input bit sizes,
                              input logic [CFG_DATA_W-1:0] w_d,
                              input logic [CFG_DATA_W-1:0] h_d, input bit stray);
    wait_idle();
    write_reg(REG_THRESHOLD, thr_d);
    if (sizes) begin
      write_reg(REG_WIDTH, w_d);
      write_reg(REG_HEIGHT, h_d);
    end
    if (stray) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = 200;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        hold = $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] thr_d, w_d, h_d;
    int unsigned frames;
    foreach (row_above[i]) row_above[i] = '0;
    foreach (row_mid[i]) row_mid[i] = '0;
    foreach (nbhd[i]) nbhd[i] = '0;
    restart_frame();
    thr_reg    = THRESHOLD_RST;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frames, width and height written below the clamp limit
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    program_regs(16'hA514, 1'b1, 16'h0001, 16'h0000, 1'b1);
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_table[i].flush, dir_table[i].pix, dir_table[i].typed,
                out_pix_t'{dir_table[i].exp_pix, dir_table[i].exp_last});

    // threshold extremes
    program_regs(16'h5500, 1'b1, 16'h0005, 16'h0004, 1'b0);
    send_frame(1'b0);
    program_regs(16'h00FF, 1'b1, 16'hF807, 16'h0003, 1'b0);
    send_frame(1'b0);

    // long output stall with the input kept busy
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    program_regs(16'h0040, 1'b1, 16'h0006, 16'h0004, 1'b0);
    squeeze_req = 1'b1;
    send_frame(1'b0);

    // widest line and tallest frame, abandoned part way
    program_regs(16'h0030, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    for (int i = 0; i < 1030; i++) send_item(MODE_PIXEL, pick_pixel());

    fed_items = 0;
    while (fed_items < RANDOM_ITEMS) begin
      thr_d = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 5))
        0: thr_d[7:0] = 8'd0;
        1: thr_d[7:0] = 8'd255;
        2, 3: thr_d[7:0] = 8'($urandom_range(1, 60));
        default: ;
      endcase
      w_d = CFG_DATA_W'($urandom);
      w_d[IMG_W_W-1:0] = ($urandom_range(0, 19) == 0) ? IMG_W_W'($urandom_range(0, 2))
                                                       : IMG_W_W'($urandom_range(3, 10));
      h_d = ($urandom_range(0, 19) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                         : CFG_DATA_W'($urandom_range(3, 6));
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 5;
        default: src_idle_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0: sink_idle_pct = 0;
        1: sink_idle_pct = 5;
        default: sink_idle_pct = 25;
      endcase
      program_regs(thr_d, (row_pos != 0 || col_pos != 0 || $urandom_range(0, 4) != 0),
                   w_d, h_d, ($urandom_range(0, 3) == 0));
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++)
        send_frame((f == frames - 1) && ($urandom_range(0, 4) == 0));
    end

    // closing stretch without idling
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    program_regs(16'h0018, 1'b1, 16'h0005, 16'h0004, 1'b0);
    send_frame(1'b0);
    wait_idle();

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
